// ===== hw/rtl/encoder_button_serial_bridge_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the encoder button serial bridge
// Clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ENCODER_BUTTON_SERIAL_BRIDGE_TOP_DEFINES_SVH
`define ENCODER_BUTTON_SERIAL_BRIDGE_TOP_DEFINES_SVH

// Same-cycle implication.
`define EBSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EBSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ebsb_pkg.sv =====
// ---------------------------------------------------------------------------
// ebsb_pkg
// Widths, register map and the encoder step table.
// ---------------------------------------------------------------------------
package ebsb_pkg;

  localparam int unsigned NUM_BUTTONS = 8;
  localparam int unsigned BUTTON_W    = 8;
  localparam int unsigned FLAG_W      = 8;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned HIST_W      = 4;
  localparam int unsigned DELTA_W     = 8;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned FRAME_BITS  = 24;

  // APB register map
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_LONG_PRESS_TICKS = 1'b0;
  localparam logic [COUNT_W-1:0] LONG_TICKS_RST       = 8'd80;

  // Byte boundaries inside the frame
  localparam logic [POS_W-1:0] POS_SHORT = 5'd0;
  localparam logic [POS_W-1:0] POS_LONG  = 5'd8;
  localparam logic [POS_W-1:0] POS_DELTA = 5'd16;
  localparam logic [POS_W-1:0] POS_LAST  = 5'(FRAME_BITS - 1);
  localparam logic [POS_W-1:0] POS_END   = 5'(FRAME_BITS);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic {
    FUNC_TICK  = 1'b0,
    FUNC_SHIFT = 1'b1
  } func_e;

  // Half-resolution quadrature step, indexed by {old A, old B, new A, new B}
  localparam logic [DELTA_W-1:0] STEP_TABLE [16] = '{
    8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
    8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00
  };

endpackage

// ===== hw/rtl/ebsb_in_if.sv =====
// ---------------------------------------------------------------------------
// ebsb_in_if
// Request channel: sample ticks and shift clock edges.
// ---------------------------------------------------------------------------
interface ebsb_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic                          phase_a;
  logic                          phase_b;
  logic [ebsb_pkg::BUTTON_W-1:0] buttons_pressed;

  modport source (
    output valid, func, phase_a, phase_b, buttons_pressed,
    input  ready
  );
  modport sink (
    input  valid, func, phase_a, phase_b, buttons_pressed,
    output ready
  );
endinterface

// ===== hw/rtl/ebsb_out_if.sv =====
// ---------------------------------------------------------------------------
// ebsb_out_if
// Result channel: serial line level and frame position.
// ---------------------------------------------------------------------------
interface ebsb_out_if;
  logic                       valid;
  logic                       ready;
  logic                       data_bit;
  logic [ebsb_pkg::POS_W-1:0] bit_index;
  logic                       frame_end;

  modport source (
    output valid, data_bit, bit_index, frame_end,
    input  ready
  );
  modport sink (
    input  valid, data_bit, bit_index, frame_end,
    output ready
  );
endinterface

// ===== hw/rtl/encoder_button_serial_bridge_top.sv =====
// ---------------------------------------------------------------------------
// encoder_button_serial_bridge_top
// Quadrature encoder and long-press button scanner with a 24-bit serial frame.
// ---------------------------------------------------------------------------
// Usage:
//   in_i carries one request per pin event. func = tick samples the encoder
//   phases and button levels; func = shift drives the next frame bit (short
//   flags, long flags, then rotation delta, LSB first).
//   out_o returns exactly one result per request: the line level, the frame
//   position just driven and a frame end flag (both zero on ticks).
//   The result is registered: a request accepted at an edge shows its result
//   after that edge. Throughput is one request per cycle while out_o is not
//   stalled, set by the single result register; all state updates in the accept cycle.
//   in_i.ready stays high while the result register is empty or being taken
//   this cycle; a stalled receiver holds the result and stalls the sender.
//   The APB port holds long_press_ticks at address 0 (reset 80); write it
//   only while no request is in flight.
//   Reset clears all flags, counters, the delta and the frame position and
//   empties the result register.
// ---------------------------------------------------------------------------
`include "encoder_button_serial_bridge_top_defines.svh"

module encoder_button_serial_bridge_top #(
  parameter int unsigned NumButtons = ebsb_pkg::NUM_BUTTONS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ebsb_in_if.sink                        in_i,
  ebsb_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ebsb_pkg::PADDR_W-1:0]   paddr,
  input  logic [ebsb_pkg::PDATA_W-1:0]   pwdata,
  output logic [ebsb_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int unsigned CW = ebsb_pkg::COUNT_W;
  localparam int unsigned FW = ebsb_pkg::FLAG_W;
  localparam int unsigned PW = ebsb_pkg::POS_W;

  logic [CW-1:0]                     long_ticks_q;
  logic [ebsb_pkg::HIST_W-1:0]       hist_q, hist_d;
  logic [ebsb_pkg::DELTA_W-1:0]      delta_q, delta_d;
  logic [FW-1:0]                     short_q, short_d;
  logic [FW-1:0]                     long_q, long_d;
  logic [NumButtons-1:0]             held_q, held_d;
  logic [CW-1:0]                     count_q [NumButtons];
  logic [CW-1:0]                     count_d [NumButtons];
  logic [PW-1:0]                     pos_q, pos_d;
  logic [FW-1:0]                     latch_q, latch_d;
  logic                              line_q, line_d;

  logic                              out_valid_q;
  logic                              out_data_q, out_data_d;
  logic [PW-1:0]                     out_idx_q, out_idx_d;
  logic                              out_end_q, out_end_d;

  logic                              in_fire;
  logic                              cfg_write;

  // ---------------------------------------------------------------------
  // APB register
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[ebsb_pkg::PADDR_W-1:2] == ebsb_pkg::REG_LONG_PRESS_TICKS);
  assign prdata    = (paddr[ebsb_pkg::PADDR_W-1:2] == ebsb_pkg::REG_LONG_PRESS_TICKS) ?
                     {{(ebsb_pkg::PDATA_W-CW){1'b0}}, long_ticks_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks_q <= ebsb_pkg::LONG_TICKS_RST;
    end else if (cfg_write) begin
      long_ticks_q <= pwdata[CW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign out_o.valid     = out_valid_q;
  assign out_o.data_bit  = out_data_q;
  assign out_o.bit_index = out_idx_q;
  assign out_o.frame_end = out_end_q;

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    hist_d    = hist_q;
    delta_d   = delta_q;
    short_d   = short_q;
    long_d    = long_q;
    held_d    = held_q;
    count_d   = count_q;
    pos_d     = pos_q;
    latch_d   = latch_q;
    line_d    = line_q;
    out_data_d = line_q;
    out_idx_d  = '0;
    out_end_d  = 1'b0;

    if (in_fire) begin
      if (ebsb_pkg::func_e'(in_i.func) == ebsb_pkg::FUNC_TICK) begin
        hist_d  = {hist_q[1:0], in_i.phase_a, in_i.phase_b};
        delta_d = delta_q + ebsb_pkg::STEP_TABLE[hist_d];
        for (int k = 0; k < NumButtons; k++) begin
          if (in_i.buttons_pressed[k]) begin
            held_d[k] = 1'b1;
            if (count_q[k] < long_ticks_q) begin
              count_d[k] = count_q[k] + 1'b1;
            end else if (count_q[k] == long_ticks_q) begin
              long_d[k] = 1'b1;
              if (count_q[k] != ebsb_pkg::COUNT_MAX) begin
                count_d[k] = count_q[k] + 1'b1;
              end
            end
          end else if (held_q[k]) begin
            if (count_q[k] < long_ticks_q) begin
              short_d[k] = 1'b1;
            end
            count_d[k] = '0;
            held_d[k]  = 1'b0;
          end
        end
      end else if (pos_q >= ebsb_pkg::POS_END) begin
        // unreachable position: hold the line and restart the frame
        out_idx_d = pos_q;
        pos_d     = '0;
      end else begin
        // latch each byte and clear its source at the byte start
        priority if (pos_q == ebsb_pkg::POS_SHORT) begin
          latch_d = short_q;
          short_d = '0;
        end else if (pos_q == ebsb_pkg::POS_LONG) begin
          latch_d = long_q;
          long_d  = '0;
        end else if (pos_q == ebsb_pkg::POS_DELTA) begin
          latch_d = delta_q;
          delta_d = '0;
        end else begin
          latch_d = latch_q;
        end
        line_d     = latch_d[pos_q[2:0]];
        out_data_d = line_d;
        out_idx_d  = pos_q;
        out_end_d  = (pos_q == ebsb_pkg::POS_LAST);
        pos_d      = out_end_d ? '0 : pos_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // State and result registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q      <= '0;
      delta_q     <= '0;
      short_q     <= '0;
      long_q      <= '0;
      held_q      <= '0;
      pos_q       <= '0;
      latch_q     <= '0;
      line_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NumButtons; k++) begin
        count_q[k] <= '0;
      end
    end else begin
      hist_q  <= hist_d;
      delta_q <= delta_d;
      short_q <= short_d;
      long_q  <= long_d;
      held_q  <= held_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      latch_q <= latch_d;
      line_q  <= line_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
      out_idx_q  <= out_idx_d;
      out_end_q  <= out_end_d;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `EBSB_ASSERT_NOW(a_pos_in_frame, 1'b1, pos_q < ebsb_pkg::POS_END,
    "frame position left the frame")
  `EBSB_ASSERT_NOW(a_end_at_last, out_valid_q && out_end_q,
    out_idx_q == ebsb_pkg::POS_LAST, "frame end away from last bit")
  `EBSB_ASSERT_NEXT(a_tick_result, in_fire && !in_i.func,
    out_valid_q && !out_end_q && (out_idx_q == '0), "tick result carries a position")
  `EBSB_ASSERT_NEXT(a_short_cleared, in_fire && in_i.func && (pos_q == ebsb_pkg::POS_SHORT),
    short_q == '0, "short flags not cleared at frame start")

endmodule

// ===== test/encoder_button_serial_bridge_top_test.sv =====
// ---------------------------------------------------------------------------
// encoder_button_serial_bridge_top_test
// Drives sample ticks and shift clock edges through the request channel,
// predicts every serial frame bit in the bench and compares each result field.
// The long press threshold is stepped through several values over APB.
// ---------------------------------------------------------------------------
module encoder_button_serial_bridge_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD       = 20;
  localparam int RESET_CYCLES     = 7;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int LONG_HOLD_AT     = 300;
  localparam int NUM_PHASES       = 5;
  localparam int NUM_ROWS         = 25;
  localparam int MAX_PRINTED      = 40;
  localparam logic [ebsb_pkg::PADDR_W-1:0] TICKS_ADDR = {ebsb_pkg::REG_LONG_PRESS_TICKS, 2'b00};

  typedef struct packed {
    ebsb_pkg::func_e                 func;
    logic                            phase_a;
    logic                            phase_b;
    logic [ebsb_pkg::BUTTON_W-1:0]   buttons;
  } pin_event_t;

  typedef struct packed {
    logic                       data_bit;
    logic [ebsb_pkg::POS_W-1:0] bit_index;
    logic                       frame_end;
  } frame_bit_t;

  typedef struct packed {
    pin_event_t ev;
    logic       fixed;
    frame_bit_t want;
  } scan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [ebsb_pkg::PADDR_W-1:0]   paddr;
  logic [ebsb_pkg::PDATA_W-1:0]   pwdata;
  logic [ebsb_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;

  ebsb_in_if  in_ch ();
  ebsb_out_if out_ch ();

  encoder_button_serial_bridge_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Scanner state as the bench sees it
  logic [ebsb_pkg::COUNT_W-1:0] long_ticks;
  logic [ebsb_pkg::HIST_W-1:0]  phase_hist;
  logic [ebsb_pkg::DELTA_W-1:0] turn_delta;
  logic [ebsb_pkg::FLAG_W-1:0]  short_seen;
  logic [ebsb_pkg::FLAG_W-1:0]  long_seen;
  logic [ebsb_pkg::FLAG_W-1:0]  held_now;
  logic [ebsb_pkg::COUNT_W-1:0] held_ticks [ebsb_pkg::NUM_BUTTONS];
  logic [ebsb_pkg::POS_W-1:0]   frame_pos;
  logic [7:0]                   shift_byte;
  logic                         line_lvl;

  frame_bit_t expected_bits_q [$];

  int errors       = 0;
  int cycle_count  = 0;
  int results_seen = 0;
  int frames_done  = 0;
  int ticks_sent   = 0;
  int shifts_sent  = 0;
  int idle_pct     = 0;
  int stall_left   = 0;
  bit long_hold_done = 1'b0;

  // Stimulus shaping: encoder position in Gray order and per-button press plans
  logic [1:0]                    enc_pos = '0;
  bit                            enc_fwd = 1'b1;
  logic [ebsb_pkg::FLAG_W-1:0]   press_plan = '0;
  int                            press_left [ebsb_pkg::NUM_BUTTONS];

  scan_row_t scan_rows [NUM_ROWS] = '{
    // threshold 2: ticks walk the encoder, long press all, short press 7 and 0
    '{'{ebsb_pkg::FUNC_TICK,  1'b0, 1'b0, 8'h00}, 1'b1, '{1'b0, 5'd0, 1'b0}},
    '{'{ebsb_pkg::FUNC_TICK,  1'b0, 1'b1, 8'hFF}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_TICK,  1'b1, 1'b1, 8'hFF}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_TICK,  1'b1, 1'b0, 8'hFF}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_TICK,  1'b0, 1'b0, 8'h01}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_TICK,  1'b1, 1'b0, 8'h00}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_TICK,  1'b1, 1'b1, 8'h80}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_TICK,  1'b0, 1'b1, 8'h01}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_TICK,  1'b0, 1'b0, 8'h00}, 1'b0, '0},
    // short byte: buttons 0 and 7
    '{'{ebsb_pkg::FUNC_SHIFT, 1'b1, 1'b1, 8'hFF}, 1'b1, '{1'b1, 5'd0, 1'b0}},
    '{'{ebsb_pkg::FUNC_SHIFT, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_SHIFT, 1'b1, 1'b0, 8'h55}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_SHIFT, 1'b0, 1'b1, 8'hAA}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_SHIFT, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_SHIFT, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_SHIFT, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_SHIFT, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
    // long byte: every button was held long
    '{'{ebsb_pkg::FUNC_SHIFT, 1'b0, 1'b0, 8'h00}, 1'b1, '{1'b1, 5'd8, 1'b0}},
    '{'{ebsb_pkg::FUNC_SHIFT, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_SHIFT, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_SHIFT, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_SHIFT, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_SHIFT, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_SHIFT, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
    '{'{ebsb_pkg::FUNC_SHIFT, 1'b0, 1'b0, 8'h00}, 1'b0, '0}
  };

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want,
               cycle_count);
    end
  endtask

  task automatic reset_scanner();
    long_ticks = ebsb_pkg::LONG_TICKS_RST;
    phase_hist = '0;
    turn_delta = '0;
    short_seen = '0;
    long_seen  = '0;
    held_now   = '0;
    frame_pos  = '0;
    shift_byte = '0;
    line_lvl   = 1'b0;
    for (int k = 0; k < ebsb_pkg::NUM_BUTTONS; k++) begin
      held_ticks[k] = '0;
      press_left[k] = 0;
    end
  endtask

  // Advance the bench copy of the scanner by one request and return its frame bit
  task automatic scan_event(input pin_event_t ev, output frame_bit_t res);
    logic [ebsb_pkg::POS_W-1:0] p;
    if (ev.func == ebsb_pkg::FUNC_TICK) begin
      phase_hist = {phase_hist[1:0], ev.phase_a, ev.phase_b};
      case (phase_hist)
        4'b0111, 4'b1000: turn_delta = turn_delta + 8'd1;
        4'b0010, 4'b1101: turn_delta = turn_delta - 8'd1;
        default: ;
      endcase
      for (int k = 0; k < ebsb_pkg::NUM_BUTTONS; k++) begin
        if (ev.buttons[k]) begin
          held_now[k] = 1'b1;
          if (held_ticks[k] < long_ticks) begin
            held_ticks[k] = held_ticks[k] + 8'd1;
          end else if (held_ticks[k] == long_ticks) begin
            long_seen[k] = 1'b1;
            if (held_ticks[k] != ebsb_pkg::COUNT_MAX) held_ticks[k] = held_ticks[k] + 8'd1;
          end
        end else if (held_now[k]) begin
          if (held_ticks[k] < long_ticks) short_seen[k] = 1'b1;
          held_ticks[k] = '0;
          held_now[k]   = 1'b0;
        end
      end
      res = '{data_bit: line_lvl, bit_index: '0, frame_end: 1'b0};
    end else begin
      p = frame_pos;
      // latch and clear the source at each byte start
      case (p)
        ebsb_pkg::POS_SHORT: begin
          shift_byte = short_seen;
          short_seen = '0;
        end
        ebsb_pkg::POS_LONG: begin
          shift_byte = long_seen;
          long_seen  = '0;
        end
        ebsb_pkg::POS_DELTA: begin
          shift_byte = turn_delta;
          turn_delta = '0;
        end
        default: ;
      endcase
      line_lvl  = shift_byte[p[2:0]];
      res       = '{data_bit: line_lvl, bit_index: p,
                    frame_end: (p == ebsb_pkg::POS_LAST)};
      frame_pos = (p == ebsb_pkg::POS_LAST) ? '0 : p + 5'd1;
    end
  endtask

  task automatic apb_access(input bit wr, input logic [ebsb_pkg::PDATA_W-1:0] wdata,
                            output logic [ebsb_pkg::PDATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= TICKS_ADDR;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_long_ticks(input logic [ebsb_pkg::COUNT_W-1:0] value);
    logic [ebsb_pkg::PDATA_W-1:0] rd;
    apb_access(1'b1, ebsb_pkg::PDATA_W'(value), rd);
    long_ticks = value;
    apb_access(1'b0, '0, rd);
    if (rd !== ebsb_pkg::PDATA_W'(value))
      report_mismatch("long_press_ticks readback", rd, value);
  endtask

  task automatic send_request(input pin_event_t ev, input logic use_fixed,
                              input frame_bit_t fixed);
    frame_bit_t predicted;
    @(negedge clk_i);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.func            <= ev.func;
    in_ch.phase_a         <= ev.phase_a;
    in_ch.phase_b         <= ev.phase_b;
    in_ch.buttons_pressed <= ev.buttons;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    scan_event(ev, predicted);
    expected_bits_q.push_back(use_fixed ? fixed : predicted);
    if (ev.func == ebsb_pkg::FUNC_TICK) ticks_sent++;
    else shifts_sent++;
  endtask

  // Drop valid, drain all results, then let the result register settle
  task automatic wait_scanner_idle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (expected_bits_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic run_scan_phase(input int n_items, input int shift_pct);
    pin_event_t ev;
    int r;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < shift_pct) begin
        ev.func    = ebsb_pkg::FUNC_SHIFT;
        ev.phase_a = 1'($urandom);
        ev.phase_b = 1'($urandom);
        ev.buttons = 8'($urandom);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) enc_fwd = ~enc_fwd;
        else if (r < 75) enc_pos = enc_fwd ? enc_pos + 2'd1 : enc_pos - 2'd1;
        else if (r >= 90) enc_pos = 2'($urandom);  // random jump, possibly an illegal transition
        for (int k = 0; k < ebsb_pkg::NUM_BUTTONS; k++) begin
          if (press_left[k] == 0) begin
            press_plan[k] = ~press_plan[k];
            if (press_plan[k]) begin
              press_left[k] = $urandom_range(0, 1) ? int'($urandom_range(1, long_ticks))
                                                   : int'(long_ticks) + $urandom_range(0, 12);
            end else begin
              press_left[k] = $urandom_range(1, 6);
            end
          end
          press_left[k]--;
        end
        ev.func    = ebsb_pkg::FUNC_TICK;
        ev.phase_a = enc_pos[1];
        ev.phase_b = enc_pos[1] ^ enc_pos[0];
        ev.buttons = ($urandom_range(0, 19) == 0) ? 8'($urandom) : press_plan;
      end
      send_request(ev, 1'b0, '0);
    end
  endtask

  // Result sink: random stalls plus one long hold-off to back up the block
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
      long_hold_done <= 1'b1;
      stall_left     <= LONG_HOLD_CYCLES - 1;
      out_ch.ready   <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left   <= $urandom_range(0, 8);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    frame_bit_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.frame_end) frames_done++;
      if (expected_bits_q.size() == 0) begin
        report_mismatch("result with nothing pending", out_ch.bit_index, 0);
      end else begin
        want = expected_bits_q.pop_front();
        if (out_ch.data_bit !== want.data_bit)
          report_mismatch("data_bit", out_ch.data_bit, want.data_bit);
        if (out_ch.bit_index !== want.bit_index)
          report_mismatch("bit_index", out_ch.bit_index, want.bit_index);
        if (out_ch.frame_end !== want.frame_end)
          report_mismatch("frame_end", out_ch.frame_end, want.frame_end);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [ebsb_pkg::PDATA_W-1:0] rd;
    int thr     [NUM_PHASES] = '{1, 254, 0, 40, 7};
    int n_items [NUM_PHASES] = '{200, 380, 180, 160, 160};
    int shifts  [NUM_PHASES] = '{30, 12, 35, 25, 30};
    int idles   [NUM_PHASES] = '{15, 25, 5, 20, 0};

    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_ch.valid           = 1'b0;
    in_ch.func            = ebsb_pkg::FUNC_TICK;
    in_ch.phase_a         = 1'b0;
    in_ch.phase_b         = 1'b0;
    in_ch.buttons_pressed = '0;
    out_ch.ready          = 1'b0;
    reset_scanner();
    thr[2] = $urandom_range(2, 60);

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    apb_access(1'b0, '0, rd);
    if (rd !== ebsb_pkg::PDATA_W'(ebsb_pkg::LONG_TICKS_RST))
      report_mismatch("long_press_ticks after reset", rd, ebsb_pkg::LONG_TICKS_RST);

    set_long_ticks(8'd2);
    idle_pct = 10;
    foreach (scan_rows[i]) send_request(scan_rows[i].ev, scan_rows[i].fixed, scan_rows[i].want);
    wait_scanner_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_long_ticks(ebsb_pkg::COUNT_W'(thr[ph]));
      idle_pct = idles[ph];
      run_scan_phase(n_items[ph], shifts[ph]);
      wait_scanner_idle();
    end

    repeat (5) @(posedge clk_i);
    $display("Run covered %0d ticks and %0d shift edges, %0d complete frames,",
             ticks_sent, shifts_sent, frames_done);
    $display("thresholds 2, 1, 254, %0d, 40 and 7, with one long receiver hold-off.",
             thr[2]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
